// File: src/ptd_pkg.sv
// shared types and constants for the point-triangle distance unit
`default_nettype none
package ptd_pkg;

  localparam int CW = 32;
  localparam int PF = 32;
  localparam int OW = CW + 1;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic signed [CW-1:0] vertex1_x;
    logic signed [CW-1:0] vertex1_y;
    logic signed [CW-1:0] vertex1_z;
    logic signed [CW-1:0] vertex2_x;
    logic signed [CW-1:0] vertex2_y;
    logic signed [CW-1:0] vertex2_z;
    logic signed [CW-1:0] vertex3_x;
    logic signed [CW-1:0] vertex3_y;
    logic signed [CW-1:0] vertex3_z;
  } ptd_in_t;

  typedef struct packed {
    logic [OW-1:0] distance;
    logic          degenerate;
  } ptd_out_t;

endpackage
`default_nettype wire

// File: src/point_triangle_distance_unit.sv
// top level: pipelined point to triangle distance in fixed point
// pipeline: setup, then the two dividers side by side, then combine,
//   then square root (input register plus one stage per root bit)
// throughput: one transaction per cycle; busy is always low
// the receiver cannot stall; out_valid pulses one cycle per transaction
// reset: synchronous active-low rst_n clears all valid bits; data regs are not reset
`default_nettype none
module point_triangle_distance_unit #(
  parameter int SQ_BITS = 66
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire ptd_pkg::ptd_in_t   in_data,
  output logic                    out_valid,
  output ptd_pkg::ptd_out_t       out_data
);
  import ptd_pkg::*;

  localparam int GW = 68;   // gram terms
  localparam int HW = GW / 2;
  localparam int WW = 140;  // products of gram terms
  localparam int NW = WW;
  localparam int QW = PF;
  localparam int SW = 2 * SQ_BITS;

  // wide signed product split into four partial products of about half width
  typedef struct packed {
    logic signed [GW-1:0] hh;
    logic signed [GW:0]   hl;
    logic signed [GW:0]   lh;
    logic [GW-1:0]        ll;
  } pp_t;

  function automatic pp_t split_mul(input logic signed [GW-1:0] a,
                                    input logic signed [GW-1:0] b);
    pp_t r;
    r.hh = $signed(a[GW-1:HW]) * $signed(b[GW-1:HW]);
    r.hl = $signed(a[GW-1:HW]) * $signed({1'b0, b[HW-1:0]});
    r.lh = $signed({1'b0, a[HW-1:0]}) * $signed(b[GW-1:HW]);
    r.ll = a[HW-1:0] * b[HW-1:0];
    return r;
  endfunction

  function automatic logic signed [WW-1:0] join_mul(input pp_t p);
    return (WW'(p.hh) <<< GW) + ((WW'(p.hl) + WW'(p.lh)) <<< HW) + WW'(p.ll);
  endfunction

  assign busy = 1'b0;

  // stage 1: differences
  logic               v1_r;
  logic signed [CW:0] e0_r [3], e1_r [3], df_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= start;
  end
  always_ff @(posedge clk) begin
    e0_r[0] <= CW'(0) + in_data.vertex2_x - in_data.vertex1_x;
    e0_r[1] <= CW'(0) + in_data.vertex2_y - in_data.vertex1_y;
    e0_r[2] <= CW'(0) + in_data.vertex2_z - in_data.vertex1_z;
    e1_r[0] <= CW'(0) + in_data.vertex3_x - in_data.vertex1_x;
    e1_r[1] <= CW'(0) + in_data.vertex3_y - in_data.vertex1_y;
    e1_r[2] <= CW'(0) + in_data.vertex3_z - in_data.vertex1_z;
    df_r[0] <= CW'(0) + in_data.vertex1_x - in_data.point_x;
    df_r[1] <= CW'(0) + in_data.vertex1_y - in_data.point_y;
    df_r[2] <= CW'(0) + in_data.vertex1_z - in_data.point_z;
  end

  // stage 2: products, stage 3: gram sums
  logic v2_r, v3_r;
  logic signed [2*CW+1:0] p_r [5][3];
  logic signed [GW-1:0] a00_r, a01_r, a11_r, b0_r, b1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p_r[0][i] <= e0_r[i] * e0_r[i];
      p_r[1][i] <= e0_r[i] * e1_r[i];
      p_r[2][i] <= e1_r[i] * e1_r[i];
      p_r[3][i] <= df_r[i] * e0_r[i];
      p_r[4][i] <= df_r[i] * e1_r[i];
    end
    a00_r <= GW'(p_r[0][0]) + GW'(p_r[0][1]) + GW'(p_r[0][2]);
    a01_r <= GW'(p_r[1][0]) + GW'(p_r[1][1]) + GW'(p_r[1][2]);
    a11_r <= GW'(p_r[2][0]) + GW'(p_r[2][1]) + GW'(p_r[2][2]);
    b0_r  <= GW'(p_r[3][0]) + GW'(p_r[3][1]) + GW'(p_r[3][2]);
    b1_r  <= GW'(p_r[4][0]) + GW'(p_r[4][1]) + GW'(p_r[4][2]);
  end

  // stage 4: partial products of the second order terms, then assembled
  logic v4_r, vm_r, v5_r;
  pp_t pp_r [6];
  logic signed [WW-1:0] m_r [6];
  logic signed [GW-1:0] a00_4_r, a01_4_r, a11_4_r, b0_4_r, b1_4_r;
  logic signed [GW-1:0] a00_m_r, a01_m_r, a11_m_r, b0_m_r, b1_m_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      vm_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
      vm_r <= v4_r;
      v5_r <= vm_r;
    end
  end
  always_ff @(posedge clk) begin
    pp_r[0] <= split_mul(a00_r, a11_r);
    pp_r[1] <= split_mul(a01_r, a01_r);
    pp_r[2] <= split_mul(a01_r, b1_r);
    pp_r[3] <= split_mul(a11_r, b0_r);
    pp_r[4] <= split_mul(a01_r, b0_r);
    pp_r[5] <= split_mul(a00_r, b1_r);
    a00_4_r <= a00_r;
    a01_4_r <= a01_r;
    a11_4_r <= a11_r;
    b0_4_r  <= b0_r;
    b1_4_r  <= b1_r;
  end
  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) m_r[i] <= join_mul(pp_r[i]);
    a00_m_r <= a00_4_r;
    a01_m_r <= a01_4_r;
    a11_m_r <= a11_4_r;
    b0_m_r  <= b0_4_r;
    b1_m_r  <= b1_4_r;
  end

  // stage 5: det, t0, t1, den
  logic signed [WW-1:0] det_r, t0_r, t1_r;
  logic signed [WW-1:0] a00_5_r, a01_5_r, a11_5_r, b0_5_r, b1_5_r, den_r;
  always_ff @(posedge clk) begin
    det_r <= m_r[0] - m_r[1];
    t0_r  <= m_r[2] - m_r[3];
    t1_r  <= m_r[4] - m_r[5];
    a00_5_r <= WW'(a00_m_r);
    a01_5_r <= WW'(a01_m_r);
    a11_5_r <= WW'(a11_m_r);
    b0_5_r  <= WW'(b0_m_r);
    b1_5_r  <= WW'(b1_m_r);
    den_r   <= WW'(a00_m_r) - WW'(a01_m_r) - WW'(a01_m_r) + WW'(a11_m_r);
  end

  // stage 6: region selection, producing two divider jobs
  localparam logic [1:0] QM_NONE = 2'd0;
  localparam logic [1:0] QM_DIV  = 2'd1;
  localparam logic [1:0] QM_ONE  = 2'd2;
  localparam logic [1:0] QM_CMP  = 2'd3;

  logic v6_r;
  logic signed [WW-1:0] n0_r, d0_r, n1_r, d1_r;
  logic [1:0] qm0_r, qm1_r;
  logic degen6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    logic signed [WW-1:0] ma, mb, n0, d0, n1, d1;
    logic [1:0] qm0, qm1;
    logic dg;
    ma = '0;
    mb = '0;
    n0 = '0; d0 = '0; n1 = '0; d1 = '0;
    qm0 = QM_NONE;
    qm1 = QM_NONE;
    dg = 1'b0;
    if (det_r == '0) begin
      dg = 1'b1;
    end else if (t0_r + t1_r <= det_r) begin
      if (t0_r < 0) begin
        if (t1_r < 0 && b0_5_r < 0) begin
          n0 = -b0_5_r; d0 = a00_5_r; qm0 = QM_DIV;
        end else begin
          n1 = -b1_5_r; d1 = a11_5_r; qm1 = QM_DIV;
        end
      end else if (t1_r < 0) begin
        n0 = -b0_5_r; d0 = a00_5_r; qm0 = QM_DIV;
      end else begin
        n0 = t0_r; d0 = det_r; qm0 = QM_DIV;
        n1 = t1_r; d1 = det_r; qm1 = QM_DIV;
      end
    end else if (t0_r < 0) begin
      ma = a01_5_r + b0_5_r;
      mb = a11_5_r + b1_5_r;
      if (mb > ma) begin
        n0 = mb - ma; d0 = den_r; qm0 = QM_DIV; qm1 = QM_CMP;
      end else if (mb <= 0) begin
        qm1 = QM_ONE;
      end else begin
        n1 = -b1_5_r; d1 = a11_5_r; qm1 = QM_DIV;
      end
    end else if (t1_r < 0) begin
      ma = a01_5_r + b1_5_r;
      mb = a00_5_r + b0_5_r;
      if (mb > ma) begin
        n1 = mb - ma; d1 = den_r; qm1 = QM_DIV; qm0 = QM_CMP;
      end else if (mb <= 0) begin
        qm0 = QM_ONE;
      end else begin
        n0 = -b0_5_r; d0 = a00_5_r; qm0 = QM_DIV;
      end
    end else begin
      n0 = (a11_5_r + b1_5_r) - (a01_5_r + b0_5_r);
      d0 = den_r; qm0 = QM_DIV; qm1 = QM_CMP;
    end
    n0_r <= n0; d0_r <= d0; n1_r <= n1; d1_r <= d1;
    qm0_r <= qm0;
    qm1_r <= qm1;
    degen6_r <= dg;
  end

  // stage 7: clamp decisions
  logic v7_r;
  logic [NW-1:0] un0_r, ud0_r, un1_r, ud1_r;
  logic z0_r, o0_r, z1_r, o1_r;
  logic [1:0] qm0_7_r, qm1_7_r;
  logic degen7_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else v7_r <= v6_r;
  end
  always_ff @(posedge clk) begin
    un0_r <= n0_r; ud0_r <= d0_r; un1_r <= n1_r; ud1_r <= d1_r;
    z0_r <= (qm0_r != QM_DIV) || n0_r <= 0 || d0_r <= 0;
    o0_r <= n0_r >= d0_r;
    z1_r <= (qm1_r != QM_DIV) || n1_r <= 0 || d1_r <= 0;
    o1_r <= n1_r >= d1_r;
    qm0_7_r <= qm0_r;
    qm1_7_r <= qm1_r;
    degen7_r <= degen6_r;
  end

  logic dv0, dv1;
  logic [QW:0] q0d, q1d;
  ptd_div #(.NW(NW), .QW(QW)) u_div0 (
    .clk, .rst_n, .in_valid(v7_r), .in_num(un0_r), .in_den(ud0_r),
    .in_zero(z0_r), .in_one(o0_r), .out_valid(dv0), .out_q(q0d));
  ptd_div #(.NW(NW), .QW(QW)) u_div1 (
    .clk, .rst_n, .in_valid(v7_r), .in_num(un1_r), .in_den(ud1_r),
    .in_zero(z1_r), .in_one(o1_r), .out_valid(dv1), .out_q(q1d));

  // side delay line for vectors and modes
  localparam int DL = QW + 1 + 7;
  logic [1:0] qmd0_r [DL], qmd1_r [DL];
  logic       dgd_r [DL];
  logic signed [CW:0] e0d_r [DL][3], e1d_r [DL][3], dfd_r [DL][3];
  always_ff @(posedge clk) begin
    qmd0_r[0] <= qm0_7_r;
    qmd1_r[0] <= qm1_7_r;
    dgd_r[0]  <= degen7_r;
    for (int k = 1; k < DL; k++) begin
      qmd0_r[k] <= qmd0_r[k-1];
      qmd1_r[k] <= qmd1_r[k-1];
      dgd_r[k]  <= dgd_r[k-1];
      e0d_r[k]  <= e0d_r[k-1];
      e1d_r[k]  <= e1d_r[k-1];
      dfd_r[k]  <= dfd_r[k-1];
    end
    e0d_r[0] <= e0_r;
    e1d_r[0] <= e1_r;
    dfd_r[0] <= df_r;
  end
  // vector delay starts at stage 1, modes at stage 7
  localparam int VT = QW + 1 + 7;
  localparam int MT = QW + 1 - 1;

  // combine: final q, then residual vector c = df<<PF + q0*e0 + q1*e1
  logic vc1_r, vc2_r, vc3_r, vc4_r;
  logic [QW:0] fq0_r, fq1_r;
  logic dg_c1_r, dg_c2_r, dg_c3_r, dg_c4_r;
  logic signed [CW:0] ce0_r [3], ce1_r [3], cdf_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc1_r <= 1'b0; vc2_r <= 1'b0; vc3_r <= 1'b0; vc4_r <= 1'b0;
    end else begin
      vc1_r <= dv0; vc2_r <= vc1_r; vc3_r <= vc2_r; vc4_r <= vc3_r;
    end
  end

  always_ff @(posedge clk) begin
    unique case (qmd0_r[MT])
      QM_DIV:  fq0_r <= q0d;
      QM_ONE:  fq0_r <= {1'b1, {QW{1'b0}}};
      QM_CMP:  fq0_r <= {1'b1, {QW{1'b0}}} - q1d;
      default: fq0_r <= '0;
    endcase
    unique case (qmd1_r[MT])
      QM_DIV:  fq1_r <= q1d;
      QM_ONE:  fq1_r <= {1'b1, {QW{1'b0}}};
      QM_CMP:  fq1_r <= {1'b1, {QW{1'b0}}} - q0d;
      default: fq1_r <= '0;
    endcase
    dg_c1_r <= dgd_r[MT];
    ce0_r <= e0d_r[VT - 1];
    ce1_r <= e1d_r[VT - 1];
    cdf_r <= dfd_r[VT - 1];
  end

  localparam int PW = CW + QW + 3;
  logic signed [PW-1:0] pe0_r [3], pe1_r [3], pdf_r [3];
  logic signed [PW:0]   c_r [3];
  pp_t                  sqp_r [3];
  logic [2*PW+1:0]      sq_r [3];
  logic [2*PW+3:0]      sum_r;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pe0_r[i] <= $signed({1'b0, fq0_r}) * ce0_r[i];
      pe1_r[i] <= $signed({1'b0, fq1_r}) * ce1_r[i];
      pdf_r[i] <= PW'(cdf_r[i]) <<< QW;
      c_r[i]   <= (PW+1)'(pdf_r[i]) + (PW+1)'(pe0_r[i]) + (PW+1)'(pe1_r[i]);
      sqp_r[i] <= split_mul(c_r[i], c_r[i]);
      sq_r[i]  <= (2*PW+2)'(join_mul(sqp_r[i]));
    end
    sum_r <= (2*PW+4)'(sq_r[0]) + (2*PW+4)'(sq_r[1]) + (2*PW+4)'(sq_r[2]);
    dg_c2_r <= dg_c1_r;
    dg_c3_r <= dg_c2_r;
    dg_c4_r <= dg_c3_r;
  end

  // extra stages for the square assembly and the sum above
  logic vc5_r, vc6_r, dg_c5_r, dg_c6_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc5_r <= 1'b0; vc6_r <= 1'b0;
    end else begin
      vc5_r <= vc4_r; vc6_r <= vc5_r;
    end
  end
  always_ff @(posedge clk) begin
    dg_c5_r <= dg_c4_r;
    dg_c6_r <= dg_c5_r;
  end

  // pipelined restoring square root, one result bit per stage
  logic [SW-1:0] rad;
  assign rad = SW'(sum_r >> (2 * PF));

  logic [SQ_BITS:0] sv_r;
  logic [SW-1:0]    sn_r [SQ_BITS+1];
  logic [SW+1:0]    sr_r [SQ_BITS+1];
  logic [SQ_BITS-1:0] sq_root_r [SQ_BITS+1];
  logic             sd_r [SQ_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r <= '0;
    else sv_r <= {sv_r[SQ_BITS-1:0], vc6_r};
  end
  always_ff @(posedge clk) begin
    sn_r[0] <= rad;
    sr_r[0] <= '0;
    sq_root_r[0] <= '0;
    sd_r[0] <= dg_c6_r;
  end
  for (genvar b = 0; b < SQ_BITS; b++) begin : g_sq
    logic [SW+1:0] rs, tr;
    assign rs = {sr_r[b][SW-1:0], sn_r[b][SW-1:SW-2]};
    // trial value is four times the partial root plus one
    assign tr = {{(SW-SQ_BITS){1'b0}}, sq_root_r[b], 2'b01};
    always_ff @(posedge clk) begin
      sn_r[b+1] <= {sn_r[b][SW-3:0], 2'b00};
      sd_r[b+1] <= sd_r[b];
      if (rs >= tr) begin
        sr_r[b+1] <= rs - tr;
        sq_root_r[b+1] <= {sq_root_r[b][SQ_BITS-2:0], 1'b1};
      end else begin
        sr_r[b+1] <= rs;
        sq_root_r[b+1] <= {sq_root_r[b][SQ_BITS-2:0], 1'b0};
      end
    end
  end

  logic [SQ_BITS-1:0] root;
  assign root = sq_root_r[SQ_BITS];
  assign out_valid = sv_r[SQ_BITS];
  always_comb begin
    out_data.degenerate = sd_r[SQ_BITS];
    if (root > SQ_BITS'({OW{1'b1}})) out_data.distance = '1;
    else out_data.distance = OW'(root);
  end

  // both dividers run in lock step
  a_div_lock: assert property (@(posedge clk) disable iff (!rst_n) dv0 == dv1)
    else $error("divider valid mismatch");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n) v7_r |-> ##(QW+1) dv0)
    else $error("divider latency slip");
  a_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
endmodule
`default_nettype wire

// File: src/ptd_div.sv
// pipelined restoring divider, one quotient bit per stage, clamped to [0, one]
`default_nettype none
module ptd_div #(
  parameter int NW = 132,
  parameter int QW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [NW-1:0] in_den,
  input  wire logic          in_zero,
  input  wire logic          in_one,
  output logic               out_valid,
  output logic [QW:0]        out_q
);
  // the remainder stays below den at every stage when num < den
  logic [QW:0]        v_r;
  logic [NW-1:0]      rem_r [QW+1];
  logic [NW-1:0]      den_r [QW+1];
  logic [QW-1:0]      q_r   [QW+1];
  logic [1:0]         cl_r  [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= in_num;
    den_r[0] <= in_den;
    q_r[0]   <= '0;
    cl_r[0]  <= {in_one, in_zero};
  end

  for (genvar i = 0; i < QW; i++) begin : g_st
    logic [NW:0] sh;
    logic [NW:0] df;
    assign sh = {rem_r[i], 1'b0};
    assign df = sh - {1'b0, den_r[i]};
    always_ff @(posedge clk) begin
      den_r[i+1] <= den_r[i];
      cl_r[i+1]  <= cl_r[i];
      if (!df[NW]) begin
        rem_r[i+1] <= df[NW-1:0];
        q_r[i+1]   <= {q_r[i][QW-2:0], 1'b1};
      end else begin
        rem_r[i+1] <= sh[NW-1:0];
        q_r[i+1]   <= {q_r[i][QW-2:0], 1'b0};
      end
    end
  end

  assign out_valid = v_r[QW];
  always_comb begin
    if (cl_r[QW][0]) out_q = '0;
    else if (cl_r[QW][1]) out_q = {1'b1, {QW{1'b0}}};
    else out_q = {1'b0, q_r[QW]};
  end
endmodule
`default_nettype wire

// File: test/testbench.sv
// self-checking testbench for the point-triangle distance unit
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import ptd_pkg::*;

  typedef logic signed [255:0] wide_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 300;
  localparam logic [63:0] PARAM_ONE = 64'h1_0000_0000;
  localparam int ONE = 65536;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  ptd_in_t in_data;
  logic out_valid;
  ptd_out_t out_data;

  ptd_in_t pending_q[$];
  ptd_out_t dist_expected_q[$];
  int errors;
  int gap_left;
  bit no_idle_mode;
  int idle_cycles;
  bit stimulus_done;

  point_triangle_distance_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // clamped truncating division, both operands as exact integers
  function automatic logic [63:0] clamp_div(input wide_t num, input wide_t den);
    wide_t q;
    if (num <= 0 || den <= 0) return 64'd0;
    if (num >= den) return PARAM_ONE;
    q = (num <<< 32) / den;
    return q[63:0];
  endfunction

  function automatic logic [255:0] floor_sqrt(input logic [255:0] n);
    logic [255:0] r;
    logic [255:0] c;
    r = '0;
    for (int b = 127; b >= 0; b--) begin
      c = r | (256'd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic ptd_out_t predict_distance(input ptd_in_t it);
    wide_t p[3], v1[3], e0[3], e1[3], df[3];
    wide_t a00, a01, a11, b0, b1, det, t0, t1, den, m0, m1, sum, c, qa, qb;
    logic [63:0] q0, q1;
    logic [255:0] root;
    ptd_out_t r;
    p[0] = wide_t'(it.point_x);  p[1] = wide_t'(it.point_y);  p[2] = wide_t'(it.point_z);
    v1[0] = wide_t'(it.vertex1_x); v1[1] = wide_t'(it.vertex1_y);
    v1[2] = wide_t'(it.vertex1_z);
    e0[0] = wide_t'(it.vertex2_x) - v1[0]; e0[1] = wide_t'(it.vertex2_y) - v1[1];
    e0[2] = wide_t'(it.vertex2_z) - v1[2];
    e1[0] = wide_t'(it.vertex3_x) - v1[0]; e1[1] = wide_t'(it.vertex3_y) - v1[1];
    e1[2] = wide_t'(it.vertex3_z) - v1[2];
    for (int i = 0; i < 3; i++) df[i] = v1[i] - p[i];
    a00 = 0; a01 = 0; a11 = 0; b0 = 0; b1 = 0;
    for (int i = 0; i < 3; i++) begin
      a00 += e0[i] * e0[i];
      a01 += e0[i] * e1[i];
      a11 += e1[i] * e1[i];
      b0 += df[i] * e0[i];
      b1 += df[i] * e1[i];
    end
    det = a00 * a11 - a01 * a01;
    t0 = a01 * b1 - a11 * b0;
    t1 = a01 * b0 - a00 * b1;
    den = a00 - 2 * a01 + a11;
    q0 = '0;
    q1 = '0;
    r.degenerate = 1'b0;
    if (det == 0) begin
      r.degenerate = 1'b1;
    end else if (t0 + t1 <= det) begin
      if (t0 < 0) begin
        if (t1 < 0 && b0 < 0) q0 = clamp_div(-b0, a00);
        else q1 = clamp_div(-b1, a11);
      end else if (t1 < 0) begin
        q0 = clamp_div(-b0, a00);
      end else begin
        q0 = clamp_div(t0, det);
        q1 = clamp_div(t1, det);
      end
    end else if (t0 < 0) begin
      m0 = a01 + b0;
      m1 = a11 + b1;
      if (m1 > m0) begin
        q0 = clamp_div(m1 - m0, den);
        q1 = PARAM_ONE - q0;
      end else if (m1 <= 0) q1 = PARAM_ONE;
      else q1 = clamp_div(-b1, a11);
    end else if (t1 < 0) begin
      m0 = a01 + b1;
      m1 = a00 + b0;
      if (m1 > m0) begin
        q1 = clamp_div(m1 - m0, den);
        q0 = PARAM_ONE - q1;
      end else if (m1 <= 0) q0 = PARAM_ONE;
      else q0 = clamp_div(-b0, a00);
    end else begin
      q0 = clamp_div((a11 + b1) - (a01 + b0), den);
      q1 = PARAM_ONE - q0;
    end
    qa = '0; qa[63:0] = q0;
    qb = '0; qb[63:0] = q1;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      c = (df[i] <<< 32) + qa * e0[i] + qb * e1[i];
      sum += c * c;
    end
    root = floor_sqrt(sum >> 64);
    if (root > {OW{1'b1}}) r.distance = {OW{1'b1}};
    else r.distance = root[OW-1:0];
    return r;
  endfunction

  function automatic ptd_in_t make_item(input int x0, y0, z0, x1, y1, z1,
                                        x2, y2, z2, x3, y3, z3);
    ptd_in_t it;
    it = '{x0, y0, z0, x1, y1, z1, x2, y2, z2, x3, y3, z3};
    return it;
  endfunction

  // coordinate styles: full range, small scene, near the extremes
  function automatic logic [31:0] rand_coord(input int style);
    case (style)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 255)
                                            : 32'h8000_0000 + $urandom_range(0, 255);
    endcase
  endfunction

  function automatic ptd_in_t rand_item();
    ptd_in_t it;
    int style, shape;
    style = $urandom_range(0, 9) < 6 ? 1 : ($urandom_range(0, 2) == 0 ? 2 : 0);
    it = '{rand_coord(style), rand_coord(style), rand_coord(style),
           rand_coord(style), rand_coord(style), rand_coord(style),
           rand_coord(style), rand_coord(style), rand_coord(style),
           rand_coord(style), rand_coord(style), rand_coord(style)};
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      // coincident vertices
      it.vertex3_x = it.vertex1_x; it.vertex3_y = it.vertex1_y; it.vertex3_z = it.vertex1_z;
    end else if (shape == 1 && style == 1) begin
      // collinear: third vertex at twice the first edge
      it.vertex3_x = 2 * it.vertex2_x - it.vertex1_x;
      it.vertex3_y = 2 * it.vertex2_y - it.vertex1_y;
      it.vertex3_z = 2 * it.vertex2_z - it.vertex1_z;
    end
    return it;
  endfunction

  function automatic int next_gap();
    int r;
    if (no_idle_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    errors = 0;
    gap_left = 0;
    no_idle_mode = 1'b0;
    stimulus_done = 1'b0;
    // unit right triangle in the z = 0 plane, query point in each region
    pending_q.push_back(make_item(ONE/4, ONE/4, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    pending_q.push_back(make_item(ONE/2, -ONE, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    pending_q.push_back(make_item(-ONE, ONE/2, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    pending_q.push_back(make_item(ONE, ONE, -ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    pending_q.push_back(make_item(-ONE, -ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    pending_q.push_back(make_item(2*ONE, -ONE/2, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    pending_q.push_back(make_item(-ONE/2, 2*ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    pending_q.push_back(make_item(3*ONE, -ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    pending_q.push_back(make_item(-ONE, 3*ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    pending_q.push_back(make_item(ONE/3, ONE/3, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    // degenerate: all zero, collinear, coincident vertices
    pending_q.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(ONE, 2*ONE, 3*ONE, 0, 0, 0, ONE, ONE, ONE,
                                  2*ONE, 2*ONE, 2*ONE));
    pending_q.push_back(make_item(5, -7, 9, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
    // field extremes, largest distances
    pending_q.push_back(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                  32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_ffff,
                                  32'h7fff_fffe, 32'h7fff_ffff, 32'h7fff_ffff));
    pending_q.push_back(make_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
    pending_q.push_back(make_item(32'hffff_ffff, 0, 32'h7fff_ffff, 32'h8000_0000, 0,
                                  32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0,
                                  0, 32'h7fff_ffff, 32'h7fff_ffff));
    pending_q.push_back(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    for (int i = 0; i < 500; i++) pending_q.push_back(rand_item());
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_q.size() == 0 && dist_expected_q.size() == 0);
    @(posedge clk);
    wait (!start && dist_expected_q.size() == 0);
    stimulus_done = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && dist_expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) dist_expected_q.push_back(predict_distance(in_data));
      if ($urandom_range(0, 199) == 0) no_idle_mode = !no_idle_mode;
      // a transaction still waiting keeps start high
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_data <= pending_q.pop_front();
        start <= 1'b1;
        gap_left = next_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (dist_expected_q.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        ptd_out_t exp_r;
        exp_r = dist_expected_q.pop_front();
        if (out_data.distance !== exp_r.distance)
          report_mismatch($sformatf("distance got %h want %h",
                                    out_data.distance, exp_r.distance));
        if (out_data.degenerate !== exp_r.degenerate)
          report_mismatch($sformatf("degenerate got %b want %b",
                                    out_data.degenerate, exp_r.degenerate));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || stimulus_done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
`default_nettype wire
